@@ rtl/vzd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vzd_pkg
// Shared types and constants for the varint / zigzag decoder.
// ----------------------------------------------------------------------------
package vzd_pkg;

    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int PAYLOAD_W   = 7;
    localparam int SHIFT_W     = 6;
    localparam int NARROW_W    = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(10);

    // Bit 7 of a stream byte says another byte follows
    localparam int CONT_BIT = 7;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERLONG  = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic {
        CFG_ZIGZAG_ENABLE = 1'b0,
        CFG_NARROW_MODE   = 1'b1
    } cfg_index_t;

    // One finished varint or error, before zigzag / narrowing
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } result_t;

endpackage : vzd_pkg
`default_nettype wire

@@ rtl/vzd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vzd_front
// Accepts stream bytes, gathers the 7-bit payloads and classifies each byte
// as continue, finished varint, overlong or truncated.
// ----------------------------------------------------------------------------
module vzd_front
    import vzd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    input  wire logic              q_full,
    output logic                   q_push,
    output result_t                q_data
);

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic [SHIFT_W-1:0] shift_full;
    logic [VALUE_W-1:0] merged;
    logic [COUNT_W-1:0] count;
    logic               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // At most nine bytes precede this one, so the offset stays below 64
    assign shift_full = SHIFT_W'(seen_reg) * SHIFT_W'(PAYLOAD_W);
    assign merged     = acc_reg |
                        (VALUE_W'(in_byte[PAYLOAD_W-1:0]) << shift_full);
    assign count      = seen_reg + COUNT_W'(1);

    always_comb
    begin
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        q_push         = 1'b0;
        q_data.value   = '0;
        q_data.count   = count;
        q_data.status  = STATUS_OK;
        if (accept)
        begin
            acc_next  = '0;
            seen_next = '0;
            q_push    = 1'b1;
            if (!in_byte[CONT_BIT])
            begin
                q_data.value = merged;
            end
            else if (count == MAX_BYTES)
            begin
                q_data.count  = MAX_BYTES;
                q_data.status = STATUS_OVERLONG;
            end
            else if (in_last)
            begin
                q_data.status = STATUS_TRUNCATED;
            end
            else
            begin
                // hold the partial value, wait for the next byte
                acc_next  = merged;
                seen_next = count;
                q_push    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
        end
    end

endmodule : vzd_front
`default_nettype wire

@@ rtl/vzd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vzd_queue
// Short register queue between the front and back stages.
// ----------------------------------------------------------------------------
module vzd_queue
    import vzd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  result_t      push_data,
    output logic         full,
    input  wire logic    pop,
    output result_t      pop_data,
    output logic         not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule : vzd_queue
`default_nettype wire

@@ rtl/vzd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vzd_back
// Holds the mode registers, applies narrowing and zigzag to finished values
// and drives the registered result stream.
// ----------------------------------------------------------------------------
module vzd_back
    import vzd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic               cfg_wdata,
    input  wire logic               q_not_empty,
    input  result_t                 q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [VALUE_W-1:0]      out_value,
    output logic [COUNT_W-1:0]      out_count,
    output logic [1:0]              out_status
);

    logic               zigzag_reg;
    logic               narrow_reg;
    logic               valid_reg;
    result_t            res_reg;
    logic               load;
    logic [VALUE_W-1:0] finished;
    logic [NARROW_W-1:0] low;

    assign low = q_data.value[NARROW_W-1:0];

    always_comb
    begin
        finished = q_data.value;
        if (narrow_reg)
        begin
            finished = VALUE_W'(low);
            if (zigzag_reg)
            begin
                finished = VALUE_W'((low >> 1) ^ {NARROW_W{low[0]}});
            end
        end
        else if (zigzag_reg)
        begin
            finished = (q_data.value >> 1) ^ {VALUE_W{q_data.value[0]}};
        end
    end

    // Refill the output stage when it is empty or being drained
    assign load  = !valid_reg || out_ready;
    assign q_pop = load && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zigzag_reg <= 1'b1;
            narrow_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_ZIGZAG_ENABLE: zigzag_reg <= cfg_wdata;
                    CFG_NARROW_MODE:   narrow_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
            if (load)
            begin
                valid_reg <= q_not_empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg.value  <= (q_data.status == STATUS_OK) ? finished : '0;
            res_reg.count  <= q_data.count;
            res_reg.status <= q_data.status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_value  = res_reg.value;
    assign out_count  = res_reg.count;
    assign out_status = res_reg.status;

endmodule : vzd_back
`default_nettype wire

@@ rtl/varint_zigzag_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_zigzag_decoder
// Decodes protobuf-style varints from a byte stream, with optional 32-bit
// narrowing and zigzag decoding.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle while the queue has room. The front
// stage writes the result of the byte that ends a varint into a small queue
// and the back stage moves it from there into the output register. The queue
// depth sets how many results can wait before the input stalls; tready drops
// only when the queue is full. Mode registers take effect on results that
// leave the queue after the write.
// ----------------------------------------------------------------------------
module varint_zigzag_decoder
    import vzd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // buffer_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [63:0] value_out, [67:64] byte_count, rest 0
    output logic [1:0]       m_tuser    // [1:0] status
);

    logic               q_full;
    logic               q_push;
    result_t            q_in;
    logic               q_pop;
    result_t            q_out;
    logic               q_not_empty;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] byte_count;

    vzd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    vzd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    vzd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (value_out),
        .out_count   (byte_count),
        .out_status  (m_tuser)
    );

    assign m_tdata = {4'b0, byte_count, value_out};

endmodule : varint_zigzag_decoder
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for varint_zigzag_decoder. Byte streams of well-formed,
// overlong, truncated and random varints are fed in under random idling on
// both stream sides; every decoded value is predicted in the bench and checked
// field by field, under every setting of the zigzag and narrow modes.
// ----------------------------------------------------------------------------
module testbench;
    import vzd_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic [3:0]  count;
        status_t     status;
    } varint_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] data_byte
    logic        s_tlast   = 1'b0;    // buffer_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;             // [63:0] value_out, [67:64] byte_count, rest 0
    logic [1:0]  m_tuser;             // [1:0] status

    // Decoder state as the bench sees it
    logic [63:0] partial_value;
    int          partial_len;
    logic        zigzag_on;
    logic        narrow_on;

    varint_result_t decoded_queue[$];
    varint_result_t want;
    int             error_count;
    int             bytes_sent;
    bit             sender_full_rate;
    bit             sink_full_rate;
    int             sink_hold;
    int             sink_next;

    varint_zigzag_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] apply_modes(input logic [63:0] raw);
        logic [63:0] v;
        v = raw;
        if (narrow_on)
        begin
            v = {32'd0, v[31:0]};
            if (zigzag_on)
                v = {32'd0, {1'b0, v[31:1]} ^ {32{v[0]}}};
        end
        else if (zigzag_on)
        begin
            v = {1'b0, v[63:1]} ^ {64{v[0]}};
        end
        return v;
    endfunction

    // Advance the decoder by one byte; returns 1 when the byte finishes a result
    function automatic bit varint_step(input logic [7:0] b, input logic last,
                                       output varint_result_t r);
        int count;
        if (7 * partial_len < 64)
            partial_value = partial_value | (64'(b[6:0]) << (7 * partial_len));
        count = partial_len + 1;
        r.value = 64'd0;
        r.count = 4'(count);
        if (!b[CONT_BIT])
        begin
            r.value = apply_modes(partial_value);
            r.status = STATUS_OK;
        end
        else if (count >= int'(MAX_BYTES))
        begin
            r.count = MAX_BYTES;
            r.status = STATUS_OVERLONG;
        end
        else if (last)
        begin
            r.status = STATUS_TRUNCATED;
        end
        else
        begin
            partial_len = count;
            return 1'b0;
        end
        partial_value = 64'd0;
        partial_len = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 30)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Drive one byte and hold it until the decoder takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        varint_result_t r;
        gap = sender_full_rate ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        if (varint_step(b, last, r))
            decoded_queue.push_back(r);
    endtask

    // Hold off the sender until every decoded result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (decoded_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_ZIGZAG_ENABLE)
            zigzag_on = val;
        else
            narrow_on = val;
    endtask

    // Minimal encoding of a value
    task automatic send_value(input logic [63:0] v, input logic end_flag);
        logic [63:0] rest;
        logic        more;
        rest = v;
        do
        begin
            more = (rest >> 7) != 64'd0;
            send_byte({more, rest[6:0]}, end_flag && !more);
            rest = rest >> 7;
        end
        while (more);
    endtask

    // Continuation bytes with random payload, the last one optionally a closing byte
    task automatic send_run(input int len, input bit close, input logic end_flag);
        for (int i = 0; i < len; i++)
        begin
            if (close && i == len - 1)
                send_byte({1'b0, 7'($urandom_range(0, 127))}, end_flag);
            else
                send_byte({1'b1, 7'($urandom_range(0, 127))}, end_flag && i == len - 1);
        end
    endtask

    task automatic send_random_stream(input int n_bytes);
        int stop_at;
        int kind;
        int width;
        logic [63:0] v;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                width = $urandom_range(0, 64);
                v = {$urandom, $urandom};
                if (width < 64)
                    v = v & ((64'd1 << width) - 64'd1);
                send_value(v, $urandom_range(0, 3) == 0);
            end
            else if (kind < 70)
                send_run($urandom_range(1, 10), 1'b1, $urandom_range(0, 3) == 0);
            else if (kind < 80)
                send_run(10 + $urandom_range(0, 3), 1'b0, 1'($urandom_range(0, 1)));
            else if (kind < 90)
                send_run($urandom_range(1, 9), 1'b0, 1'b1);
            else
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        // ten bytes, top payload bits of the last one fall off
        repeat (9) send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        // overlong with buffer end on the tenth byte: overlong wins
        repeat (9) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h85, 1'b1);
        send_byte(8'h05, 1'b1);
        wait_for_results();
    endtask

    task automatic test_mode(input logic zz, input logic nr, input int n_bytes);
        write_reg(CFG_ZIGZAG_ENABLE, zz);
        write_reg(CFG_NARROW_MODE, nr);
        send_random_stream(n_bytes);
        wait_for_results();
    endtask

    task automatic test_full_throughput();
        sender_full_rate = 1'b1;
        sink_full_rate = 1'b1;
        send_random_stream(100);
        sink_full_rate = 1'b0;
        send_random_stream(60);
        sender_full_rate = 1'b0;
        wait_for_results();
    endtask

    // Result sink with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sink_next = sink_full_rate ? 0 : $urandom_range(0, 12);
            else if (sink_hold > 0)
                sink_next = sink_hold - 1;
            else
                sink_next = 0;
            sink_hold <= sink_next;
            m_tready  <= (sink_next == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_queue.size() == 0)
                report_mismatch("result transaction with nothing pending");
            else
            begin
                want = decoded_queue.pop_front();
                if (m_tdata[63:0] !== want.value)
                    report_mismatch($sformatf("value_out %h, want %h",
                                              m_tdata[63:0], want.value));
                if (m_tdata[67:64] !== want.count)
                    report_mismatch($sformatf("byte_count %0d, want %0d",
                                              m_tdata[67:64], want.count));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_tuser, want.status));
                if (m_tdata[71:68] !== 4'd0)
                    report_mismatch($sformatf("tdata pad bits %b", m_tdata[71:68]));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        partial_value = 64'd0;
        partial_len = 0;
        zigzag_on = 1'b1;
        narrow_on = 1'b0;
        error_count = 0;
        bytes_sent = 0;
        sender_full_rate = 1'b0;
        sink_full_rate = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_mode(1'b0, 1'b0, 280);
        test_mode(1'b1, 1'b1, 280);
        test_mode(1'b0, 1'b1, 280);
        test_mode(1'b1, 1'b0, 280);
        test_full_throughput();

        wait_for_results();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
